// ===== rtl/jsv_pkg.sv =====
package jsv_pkg;

  localparam int unsigned DefMaxDepth = 64;

  typedef enum logic [3:0] {
    OP_END     = 4'd0,
    OP_LEXERR  = 4'd1,
    OP_INT     = 4'd2,
    OP_NUM     = 4'd3,
    OP_STRING  = 4'd4,
    OP_NULL    = 4'd5,
    OP_TRUE    = 4'd6,
    OP_FALSE   = 4'd7,
    OP_IDENT   = 4'd8,
    OP_SYMBOL  = 4'd9
  } opcode_e;

  typedef enum logic [2:0] {
    SYM_LBRACE = 3'd0,
    SYM_RBRACE = 3'd1,
    SYM_LBRACK = 3'd2,
    SYM_RBRACK = 3'd3,
    SYM_COLON  = 3'd4,
    SYM_COMMA  = 3'd5,
    SYM_LPAREN = 3'd6,
    SYM_RPAREN = 3'd7
  } symbol_e;

  typedef enum logic [3:0] {
    EV_OPEN_OBJ  = 4'd0,
    EV_CLOSE_OBJ = 4'd1,
    EV_OPEN_ARR  = 4'd2,
    EV_CLOSE_ARR = 4'd3,
    EV_KEY       = 4'd4,
    EV_INT       = 4'd5,
    EV_NUM       = 4'd6,
    EV_STR       = 4'd7,
    EV_NULL      = 4'd8,
    EV_TRUE      = 4'd9,
    EV_FALSE     = 4'd10,
    EV_SEP       = 4'd11,
    EV_ERR       = 4'd12
  } event_e;

  typedef enum logic [3:0] {
    ERR_NONE          = 4'd0,
    ERR_LEXER         = 4'd1,
    ERR_BAD_IDENT     = 4'd2,
    ERR_BAD_SYMBOL    = 4'd3,
    ERR_VALUE_EXP     = 4'd4,
    ERR_KEY_EXP       = 4'd5,
    ERR_COLON_EXP     = 4'd6,
    ERR_OBJ_NEXT_EXP  = 4'd7,
    ERR_ARR_NEXT_EXP  = 4'd8,
    ERR_MISMATCH_OBJ  = 4'd9,
    ERR_MISMATCH_ARR  = 4'd10,
    ERR_OVERFLOW      = 4'd11
  } error_e;

  typedef enum logic [1:0] {
    PH_VALUE = 2'd0,
    PH_KEY   = 2'd1,
    PH_COLON = 2'd2,
    PH_NEXT  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ACT_FAIL   = 3'd0,
    ACT_OPEN   = 3'd1,
    ACT_CLOSE  = 3'd2,
    ACT_SCALAR = 3'd3,
    ACT_KEY    = 3'd4,
    ACT_SEP    = 3'd5
  } action_e;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] symbol_code;
  } token_t;

  typedef struct packed {
    event_e     event_res;
    error_e     error_code;
    logic [6:0] nesting_depth;
    logic       document_done;
  } result_t;

endpackage

// ===== rtl/json_structure_validator.sv =====
// Pushdown checker of JSON structure. One classified token is accepted per
// clock and its structural event appears in the output register on the next
// cycle; a new token is taken every cycle while the output is free or being
// drained. The figure is set by a single-pass update of the parse phase,
// nesting level and empty flag, with the innermost container type held in a
// registered read of the MAX_DEPTH x 1 stack memory (push data forwarded into
// that read). The stack memory is never cleared; only entries below the
// current level are read. strict_json is written through the config channel;
// the user writes it only while the block is idle, as the block does not enforce this.
module json_structure_validator #(
  parameter int unsigned MAX_DEPTH = jsv_pkg::DefMaxDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jsv_pkg::token_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output jsv_pkg::result_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_data_i
);

  import jsv_pkg::*;

  localparam int unsigned LW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic          strict_q;
  phase_e        phase_q, phase_d;
  logic [LW-1:0] level_q, level_d;
  logic          empty_q, empty_d;
  logic          top_obj_q;
  logic          out_valid_q;
  result_t       out_data_q;

  logic          stack_mem [MAX_DEPTH];
  logic [AW-1:0] wr_addr, rd_addr;
  logic          push;
  logic          push_obj;

  logic          in_fire;
  logic          relaxed;
  logic          top_obj;
  logic [3:0]    op;
  logic [2:0]    sym;
  logic          is_sym;

  action_e       act;
  logic          arg_obj;
  error_e        fail_code;
  event_e        ev_d;
  error_e        err_d;
  logic          done_d;
  phase_e        sep_phase;
  logic [LW-1:0] close_level;
  logic [LW+6:0] depth_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign relaxed     = !strict_q;
  assign top_obj     = (level_q != '0) && top_obj_q;
  assign op          = in_data_i.opcode;
  assign sym         = in_data_i.symbol_code;
  assign is_sym      = (op == OP_SYMBOL);

  // decide what the token does
  always_comb begin
    act       = ACT_FAIL;
    arg_obj   = 1'b0;
    fail_code = ERR_NONE;
    sep_phase = PH_VALUE;
    if (op == OP_LEXERR) begin
      fail_code = ERR_LEXER;
    end else begin
      unique case (phase_q)
        PH_VALUE: begin
          if (op >= OP_INT && op <= OP_FALSE) begin
            act = ACT_SCALAR;
          end else if (op == OP_IDENT) begin
            fail_code = ERR_BAD_IDENT;
          end else if (is_sym) begin
            if (sym == SYM_LBRACE || sym == SYM_LBRACK) begin
              arg_obj = (sym == SYM_LBRACE);
              if (level_q >= LW'(MAX_DEPTH)) begin
                fail_code = ERR_OVERFLOW;
              end else begin
                act = ACT_OPEN;
              end
            end else if (sym == SYM_RBRACK && level_q != '0 && !top_obj &&
                         (relaxed || empty_q)) begin
              act = ACT_CLOSE;
            end else begin
              fail_code = ERR_BAD_SYMBOL;
            end
          end else begin
            fail_code = ERR_VALUE_EXP;
          end
        end
        PH_KEY: begin
          if (op == OP_STRING || (relaxed && op >= OP_INT && op <= OP_IDENT)) begin
            act = ACT_KEY;
          end else if (is_sym && sym == SYM_RBRACE && (relaxed || empty_q)) begin
            if (top_obj) begin
              act     = ACT_CLOSE;
              arg_obj = 1'b1;
            end else begin
              fail_code = ERR_MISMATCH_OBJ;
            end
          end else begin
            fail_code = ERR_KEY_EXP;
          end
        end
        PH_COLON: begin
          if (is_sym && sym == SYM_COLON) begin
            act       = ACT_SEP;
            sep_phase = PH_VALUE;
          end else begin
            fail_code = ERR_COLON_EXP;
          end
        end
        PH_NEXT: begin
          if (!is_sym) begin
            fail_code = top_obj ? ERR_OBJ_NEXT_EXP : ERR_ARR_NEXT_EXP;
          end else if (sym == SYM_COMMA) begin
            act       = ACT_SEP;
            sep_phase = top_obj ? PH_KEY : PH_VALUE;
          end else if (sym == SYM_RBRACE) begin
            if (top_obj) begin
              act     = ACT_CLOSE;
              arg_obj = 1'b1;
            end else begin
              fail_code = ERR_MISMATCH_OBJ;
            end
          end else if (sym == SYM_RBRACK) begin
            if (top_obj) begin
              fail_code = ERR_MISMATCH_ARR;
            end else begin
              act = ACT_CLOSE;
            end
          end else begin
            fail_code = ERR_BAD_SYMBOL;
          end
        end
        default: fail_code = ERR_BAD_SYMBOL;
      endcase
    end
  end

  // apply it to the state
  always_comb begin
    phase_d     = phase_q;
    level_d     = level_q;
    empty_d     = empty_q;
    ev_d        = EV_OPEN_OBJ;
    err_d       = ERR_NONE;
    done_d      = 1'b0;
    push        = 1'b0;
    push_obj    = arg_obj;
    close_level = (level_q != '0) ? level_q - 1'b1 : level_q;
    unique case (act)
      ACT_FAIL: begin
        ev_d    = EV_ERR;
        err_d   = fail_code;
        phase_d = PH_VALUE;
        level_d = '0;
        empty_d = 1'b1;
      end
      ACT_OPEN: begin
        push    = 1'b1;
        level_d = level_q + 1'b1;
        empty_d = 1'b1;
        ev_d    = arg_obj ? EV_OPEN_OBJ : EV_OPEN_ARR;
        phase_d = arg_obj ? PH_KEY : PH_VALUE;
      end
      ACT_CLOSE: begin
        ev_d    = arg_obj ? EV_CLOSE_OBJ : EV_CLOSE_ARR;
        level_d = close_level;
        if (close_level == '0) begin
          done_d  = 1'b1;
          phase_d = PH_VALUE;
          empty_d = 1'b1;
        end else begin
          phase_d = PH_NEXT;
          empty_d = 1'b0;
        end
      end
      ACT_SCALAR: begin
        ev_d = event_e'(op + 4'd3);
        if (level_q == '0) begin
          done_d  = 1'b1;
          phase_d = PH_VALUE;
          empty_d = 1'b1;
        end else begin
          phase_d = PH_NEXT;
          empty_d = 1'b0;
        end
      end
      ACT_KEY: begin
        ev_d    = EV_KEY;
        phase_d = PH_COLON;
      end
      ACT_SEP: begin
        ev_d    = EV_SEP;
        phase_d = sep_phase;
      end
      default: begin
        ev_d    = EV_ERR;
        err_d   = ERR_BAD_SYMBOL;
        phase_d = PH_VALUE;
        level_d = '0;
        empty_d = 1'b1;
      end
    endcase
    if (!in_fire) begin
      phase_d = phase_q;
      level_d = level_q;
      empty_d = empty_q;
      push    = 1'b0;
    end
  end

  // depth reported modulo 128
  assign depth_ext = {7'd0, level_d};

  assign wr_addr = AW'(level_q);
  assign rd_addr = (level_d == '0) ? '0 : AW'(level_d - 1'b1);

  // stack memory with registered top read, push data forwarded
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[wr_addr] <= push_obj;
    end
    if (push && wr_addr == rd_addr) begin
      top_obj_q <= push_obj;
    end else begin
      top_obj_q <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q    <= 1'b1;
      phase_q     <= PH_VALUE;
      level_q     <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        strict_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      level_q <= level_d;
      empty_q <= empty_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.event_res     <= ev_d;
      out_data_q.error_code    <= err_d;
      out_data_q.nesting_depth <= depth_ext[6:0];
      out_data_q.document_done <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(MAX_DEPTH))
    else $error("nesting level beyond MAX_DEPTH");

  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == EV_ERR |->
      out_data_o.nesting_depth == 7'd0 && !out_data_o.document_done)
    else $error("error result with depth or done set");

  a_code_only_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res != EV_ERR |-> out_data_o.error_code == ERR_NONE)
    else $error("error code on a non-error event");

  a_open_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && act == ACT_OPEN |=> level_q == $past(level_q) + 1'b1)
    else $error("open did not push");

  a_done_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && done_d |=> level_q == '0 && phase_q == PH_VALUE && empty_q)
    else $error("completed document did not restart");

endmodule
